// ===== rtl/core/mlpq_pkg.sv =====
// mlpq_pkg: shared types and constants for the multilevel priority fifo
// used by mlpq_ctrl, mlpq_dp and the top level in rtl/core; depends on nothing else
package mlpq_pkg;

  // field widths of the stream words
  localparam int LEVEL_W     = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // configuration registers
  localparam int NL_W       = 4;
  localparam int QD_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 1'd1;

  localparam logic [NL_W-1:0] NL_RESET = 4'd8;
  localparam logic [QD_W-1:0] QD_RESET = 6'd32;

  // operation kinds carried in in_tuser
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // result status codes carried in out_tuser
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_LEVEL = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // take the word on the input channel
    logic load_out;  // load dequeue result from the store read
  } mlpq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_deq;    // word on the input channel is a dequeue
  } mlpq_stat_t;

endpackage

// ===== rtl/core/mlpq_ram.sv =====
// mlpq_ram: generic single write port, single read port ram, registered read
// no dependencies
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mlpq_ctrl.sv =====
// mlpq_ctrl: handshake and sequencing state machine of the priority fifo
// depends on mlpq_pkg for the command and status structs
module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  mlpq_stat_t st,
  output mlpq_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  // output register is free when empty or drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign cmd.accept   = accept;
  assign cmd.load_out = (state_r == ST_RD);

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (st.is_deq) begin
            state_nxt = ST_RD;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // an enqueue result is offered on the next cycle
  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !st.is_deq) |=> out_valid_r)
    else $error("enqueue word gave no result");

  // a dequeue enters the read wait for the store read with the output free
  a_deq_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st.is_deq) |=> (state_r == ST_RD) && !out_valid_r)
    else $error("dequeue did not enter read wait");

  // the read wait is always followed by a result
  a_rd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("read wait produced no result");

  // read wait only ever follows an accepted dequeue
  a_rd_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r) |-> $past(accept && st.is_deq))
    else $error("read wait without a dequeue");

endmodule

// ===== rtl/core/mlpq_dp.sv =====
// mlpq_dp: datapath of the priority fifo: configuration, per-level pointers,
// empty flags, level select and result register; depends on mlpq_pkg, mlpq_ram
module mlpq_dp
  import mlpq_pkg::*;
#(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  mlpq_cmd_t              cmd,
  output mlpq_stat_t             st,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]    out_tuser
);

  localparam int PW  = $clog2(DEPTH);
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW  = $clog2(LEVELS * DEPTH);
  localparam int CW  = (PW + 1 > QD_W + 1) ? PW + 1 : QD_W + 1;
  localparam int NCW = ($clog2(LEVELS + 1) > NL_W) ? $clog2(LEVELS + 1) : NL_W;

  // configuration registers
  logic [NL_W-1:0] num_levels_r;
  logic [QD_W-1:0] queue_depth_r;

  // per-level queue state
  logic [PW-1:0]     head_r [LEVELS];
  logic [PW-1:0]     tail_r [LEVELS];
  logic [LEVELS-1:0] empty_r;

  // dequeue bookkeeping and result register
  logic                deq_found_r;
  logic [LEVEL_W-1:0]  deq_lvl_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [LEVEL_W-1:0]  out_level_r;

  logic                  in_mode;
  logic [LEVEL_W-1:0]    in_level;
  logic [VALUE_W-1:0]    in_value;
  logic [NCW-1:0]        nl;
  logic [CW-1:0]         qd_ext;
  logic [CW-1:0]         depth_act;
  logic                  lvl_ok;
  logic [LW-1:0]         enq_idx;
  logic                  enq_full;
  logic [PW-1:0]         tail_nxt;
  logic                  enq_go;
  logic                  deq_found;
  logic [LW-1:0]         deq_idx;
  logic [PW-1:0]         head_nxt;
  logic                  deq_go;
  logic [DATA_WIDTH-1:0] ram_rdata;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] dd);
    logic [CW-1:0] inc;
    inc = CW'(p) + CW'(1);
    return (inc >= dd) ? '0 : PW'(inc);
  endfunction

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return AW'(l) * AW'(DEPTH) + AW'(p);
  endfunction

  // input word fields
  assign in_mode  = in_tuser;
  assign in_level = in_tdata[LEVEL_W-1:0];
  assign in_value = in_tdata[LEVEL_W +: VALUE_W];
  assign st.is_deq = (in_mode == MODE_DEQ);

  // clamped level count and depth
  always_comb begin
    nl     = (NCW'(num_levels_r) > NCW'(LEVELS)) ? NCW'(LEVELS) : NCW'(num_levels_r);
    qd_ext = CW'(queue_depth_r);
    if (qd_ext == '0) begin
      depth_act = CW'(1);
    end else if (qd_ext > CW'(DEPTH)) begin
      depth_act = CW'(DEPTH);
    end else begin
      depth_act = qd_ext;
    end
  end

  // enqueue checks
  assign lvl_ok   = NCW'(in_level) < nl;
  assign enq_idx  = LW'(in_level);
  assign enq_full = !empty_r[enq_idx] && (tail_r[enq_idx] == head_r[enq_idx]);
  assign tail_nxt = adv(tail_r[enq_idx], depth_act);
  assign enq_go   = cmd.accept && !st.is_deq && lvl_ok && !enq_full;

  // priority select: lowest active non-empty level
  always_comb begin
    deq_found = 1'b0;
    deq_idx   = '0;
    for (int n = LEVELS - 1; n >= 0; n--) begin
      if (!empty_r[n] && (NCW'(n) < nl)) begin
        deq_found = 1'b1;
        deq_idx   = LW'(n);
      end
    end
  end

  assign head_nxt = adv(head_r[deq_idx], depth_act);
  assign deq_go   = cmd.accept && st.is_deq && deq_found;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r  <= NL_RESET;
      queue_depth_r <= QD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_LEVELS:  num_levels_r  <= cfg_data[NL_W-1:0];
        CFG_QUEUE_DEPTH: queue_depth_r <= cfg_data[QD_W-1:0];
        default: ;
      endcase
    end
  end

  // pointers and empty flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      empty_r <= '1;
    end else begin
      if (enq_go) begin
        tail_r[enq_idx]  <= tail_nxt;
        empty_r[enq_idx] <= 1'b0;
      end
      if (deq_go) begin
        head_r[deq_idx] <= head_nxt;
        if (head_nxt == tail_r[deq_idx]) begin
          empty_r[deq_idx] <= 1'b1;
        end
      end
    end
  end

  // element store
  mlpq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LEVELS * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (enq_go),
    .waddr (addr(enq_idx, tail_r[enq_idx])),
    .wdata (DATA_WIDTH'(in_value)),
    .re    (deq_go),
    .raddr (addr(deq_idx, head_r[deq_idx])),
    .rdata (ram_rdata)
  );

  // result register: enqueue on accept, dequeue after the store read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      deq_found_r <= deq_found;
      deq_lvl_r   <= LEVEL_W'(deq_idx);
      if (!st.is_deq) begin
        out_value_r <= '0;
        out_level_r <= '0;
        priority if (!lvl_ok) begin
          out_status_r <= STAT_BAD_LEVEL;
        end else if (enq_full) begin
          out_status_r <= STAT_OVERFLOW;
        end else begin
          out_status_r <= STAT_OK;
        end
      end
    end else if (cmd.load_out) begin
      if (deq_found_r) begin
        out_status_r <= STAT_OK;
        out_value_r  <= VALUE_W'(ram_rdata);
        out_level_r  <= deq_lvl_r;
      end else begin
        out_status_r <= STAT_EMPTY;
        out_value_r  <= '0;
        out_level_r  <= '0;
      end
    end
  end

  assign out_tdata = OUT_TDATA_W'({out_level_r, out_value_r});
  assign out_tuser = out_status_r;

endmodule

// ===== rtl/core/multilevel_priority_fifo.sv =====
// multilevel_priority_fifo: priority queue of per-level circular fifos
// top level; depends on mlpq_pkg, mlpq_ctrl, mlpq_dp, mlpq_ram
//
// Usage:
//   cfg channel writes num_levels (index 0) and queue_depth (index 1); it is
//   always ready, and the user must write it only while the block is idle (unchecked).
//   in channel: each word is an enqueue (tuser 0) of value at level, or a
//   dequeue (tuser 1) of the head of the lowest non-empty active level.
//   out channel: one result word per input word, in order, with a status
//   code in tuser (ok, overflow, bad level, all empty).
// Timing:
//   an enqueue's result appears in the cycle after it is taken; a dequeue
//   passes through a read-wait state for the registered read of the element
//   store, during which no new word is taken. Sustained rate is one enqueue
//   per cycle while the receiver keeps up.
//   A word is taken only while the result register is empty or being
//   drained, so a stalled receiver holds the result and stalls the input.
// Reset:
//   all levels empty, pointers at zero, num_levels 8, queue_depth 32; the
//   element store itself is not cleared, so the block is ready at once.
module multilevel_priority_fifo
  import mlpq_pkg::*;
#(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // level[2:0], value[34:3], zero pad
  input  logic                   in_tuser,   // mode[0]
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_value[31:0], out_level[34:32], zero pad
  output logic [STATUS_W-1:0]    out_tuser   // status[1:0]
);

  mlpq_cmd_t  cmd;
  mlpq_stat_t st;

  assign cfg_ready = 1'b1;

  // sequencing and handshakes
  mlpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // queues, store and result register
  mlpq_dp #(
    .LEVELS     (LEVELS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for the multilevel priority fifo
// needs mlpq_pkg and multilevel_priority_fifo; directed table, then random words
module testbench;
  import mlpq_pkg::*;

  localparam int LEVELS    = 8;
  localparam int DEPTH     = 32;
  localparam int CYCLE_CAP = 500000;
  localparam int PHASES    = 9;
  localparam int PHASE_LEN = 42;

  // one result word as the bench sees it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [LEVEL_W-1:0]  level;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  mode;
    logic [LEVEL_W-1:0]    lvl;
    logic [VALUE_W-1:0]    val;
    logic                  has_exp;
    result_t               exp;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // level[2:0], value[34:3], zero pad
  logic                   in_tuser = 1'b0; // mode[0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_value[31:0], out_level[34:32], zero pad
  logic [STATUS_W-1:0]    out_tuser;       // status[1:0]

  multilevel_priority_fifo u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor copy of the queue state and registers
  logic [VALUE_W-1:0] lvl_store [0:LEVELS*DEPTH-1];
  logic [4:0]         head_ptr [0:LEVELS-1];
  logic [4:0]         tail_ptr [0:LEVELS-1];
  logic [LEVELS-1:0]  lvl_empty = '1;
  logic [NL_W-1:0]    nl_reg = NL_RESET;
  logic [QD_W-1:0]    qd_reg = QD_RESET;

  result_t due_words [$];
  row_t    dir_rows [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      send_idle_pct = 21;
  int      recv_idle_pct = 85;

  logic [CFG_DATA_W-1:0] phase_nl [0:PHASES-1] =
    '{6'd8, 6'd1, 6'd15, 6'd4, 6'd0, 6'd2, 6'd8, 6'd6, 6'd5};
  logic [CFG_DATA_W-1:0] phase_qd [0:PHASES-1] =
    '{6'd63, 6'd1, 6'd32, 6'd2, 6'd7, 6'd0, 6'd32, 6'd3, 6'd16};

  initial begin
    for (int i = 0; i < LEVELS; i++) begin
      head_ptr[i] = '0;
      tail_ptr[i] = '0;
    end
  end

  always #5 clk = ~clk;

  // run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // compare each result word with the oldest outstanding expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[31:0], '0);
      end else begin
        want = due_words.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[31:0] !== want.value)
          report_mismatch("value", out_tdata[31:0], want.value);
        if (out_tdata[34:32] !== want.level)
          report_mismatch("level", 32'(out_tdata[34:32]), 32'(want.level));
      end
    end
  end

  function automatic int unsigned active_levels();
    return (nl_reg > LEVELS) ? LEVELS : nl_reg;
  endfunction

  function automatic logic [4:0] step_ptr(logic [4:0] p, int unsigned d);
    return (int'(p) + 1 >= d) ? 5'd0 : p + 5'd1;
  endfunction

  // predicted effect of one accepted word on the queues
  function automatic result_t serve_word(logic mode, logic [2:0] lvl, logic [31:0] val);
    result_t     r;
    int unsigned act_lv;
    int unsigned act_d;
    logic [4:0]  h;
    r = '0;
    act_lv = active_levels();
    act_d = (qd_reg == 0) ? 1 : (qd_reg > DEPTH) ? DEPTH : qd_reg;
    if (mode == MODE_ENQ) begin
      if (lvl >= act_lv) begin
        r.status = STAT_BAD_LEVEL;
      end else if (!lvl_empty[lvl] && tail_ptr[lvl] == head_ptr[lvl]) begin
        r.status = STAT_OVERFLOW;
      end else begin
        lvl_store[{lvl, tail_ptr[lvl]}] = val;
        tail_ptr[lvl] = step_ptr(tail_ptr[lvl], act_d);
        lvl_empty[lvl] = 1'b0;
        r.status = STAT_OK;
      end
    end else begin
      r.status = STAT_EMPTY;
      // lowest non-empty active level wins
      for (int n = 0; n < act_lv && r.status == STAT_EMPTY; n++) begin
        if (!lvl_empty[n]) begin
          h = head_ptr[n];
          r.status = STAT_OK;
          r.value = lvl_store[{n[2:0], h}];
          r.level = n[2:0];
          head_ptr[n] = step_ptr(h, act_d);
          if (head_ptr[n] == tail_ptr[n]) lvl_empty[n] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // drive one word and wait for it to be taken
  task automatic send_word(logic mode, logic [2:0] lvl, logic [31:0] val,
                           logic has_exp, result_t exp);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {5'd0, val, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = serve_word(mode, lvl, val);
    due_words.push_back(has_exp ? exp : predicted);
  endtask

  // stop sending and let every outstanding word come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NUM_LEVELS) nl_reg = data[NL_W-1:0];
    else qd_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word(int deq_pct);
    logic [2:0]  lvl;
    logic [31:0] val;
    int unsigned act_lv;
    act_lv = active_levels();
    lvl = 3'($urandom_range(0, 7));
    if (act_lv != 0 && $urandom_range(0, 99) < 85) lvl = 3'($urandom_range(0, act_lv - 1));
    val = $urandom;
    case ($urandom_range(0, 15))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'h0000_0000;
      3: val = 32'hFFFF_FFFF;
      default: ;
    endcase
    send_word(($urandom_range(0, 99) < deq_pct) ? MODE_DEQ : MODE_ENQ, lvl, val, 1'b0, '0);
  endtask

  // directed table builders
  function automatic void add_word(logic mode, logic [2:0] lvl, logic [31:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.mode = mode;
    r.lvl = lvl;
    r.val = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic mode, logic [2:0] lvl, logic [31:0] val,
                                      logic [1:0] st, logic [31:0] ov, logic [2:0] ol);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.mode = mode;
    r.lvl = lvl;
    r.val = val;
    r.has_exp = 1'b1;
    r.exp = '{status: st, value: ov, level: ol};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = data;
    dir_rows.push_back(r);
  endfunction

  initial begin
    // empty after reset, extremes of value, serving order by level
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_EMPTY, 32'h0, 3'd0);
    add_checked(MODE_ENQ, 3'd7, 32'h7FFF_FFFF, STAT_OK, 32'h0, 3'd0);
    add_checked(MODE_ENQ, 3'd0, 32'h8000_0000, STAT_OK, 32'h0, 3'd0);
    add_checked(MODE_DEQ, 3'd3, 32'h1234_5678, STAT_OK, 32'h8000_0000, 3'd0);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_OK, 32'h7FFF_FFFF, 3'd7);
    add_checked(MODE_DEQ, 3'd7, 32'hFFFF_FFFF, STAT_EMPTY, 32'h0, 3'd0);
    // hidden level keeps its word while out of range
    add_checked(MODE_ENQ, 3'd5, 32'hA5A5_5A5A, STAT_OK, 32'h0, 3'd0);
    add_cfg(CFG_NUM_LEVELS, 6'd2);
    add_checked(MODE_ENQ, 3'd5, 32'h1, STAT_BAD_LEVEL, 32'h0, 3'd0);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_EMPTY, 32'h0, 3'd0);
    add_checked(MODE_ENQ, 3'd1, 32'hFFFF_FFFF, STAT_OK, 32'h0, 3'd0);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_OK, 32'hFFFF_FFFF, 3'd1);
    // too many levels acts as all of them, upper data bits dropped
    add_cfg(CFG_NUM_LEVELS, 6'h3F);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_OK, 32'hA5A5_5A5A, 3'd5);
    // no active level at all
    add_cfg(CFG_NUM_LEVELS, 6'd0);
    add_checked(MODE_ENQ, 3'd0, 32'h5, STAT_BAD_LEVEL, 32'h0, 3'd0);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_EMPTY, 32'h0, 3'd0);
    // zero depth acts as one entry
    add_cfg(CFG_NUM_LEVELS, 6'd8);
    add_cfg(CFG_QUEUE_DEPTH, 6'd0);
    add_checked(MODE_ENQ, 3'd2, 32'h1, STAT_OK, 32'h0, 3'd0);
    add_checked(MODE_ENQ, 3'd2, 32'h2, STAT_OVERFLOW, 32'h0, 3'd0);
    add_checked(MODE_DEQ, 3'd0, 32'h0, STAT_OK, 32'h1, 3'd2);
    // depth lowered under held data: tail past the new depth wraps
    add_cfg(CFG_QUEUE_DEPTH, 6'd32);
    add_word(MODE_ENQ, 3'd4, 32'd11);
    add_word(MODE_ENQ, 3'd4, 32'd22);
    add_word(MODE_ENQ, 3'd4, 32'd33);
    add_cfg(CFG_QUEUE_DEPTH, 6'd2);
    add_word(MODE_ENQ, 3'd4, 32'd44);
    add_word(MODE_ENQ, 3'd4, 32'd55);
    add_word(MODE_DEQ, 3'd4, 32'd0);
    add_word(MODE_DEQ, 3'd4, 32'd0);
    add_word(MODE_DEQ, 3'd4, 32'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_cfg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_word(dir_rows[i].mode, dir_rows[i].lvl, dir_rows[i].val,
                  dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end

    // random phases, three idle regimes of three settings each
    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 21; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      settle();
      // depth only changes with every level drained
      if (phase_qd[p] != qd_reg) begin
        write_cfg(CFG_NUM_LEVELS, 6'(NL_RESET));
        while (lvl_empty != '1) send_word(MODE_DEQ, 3'($urandom_range(0, 7)), $urandom, 1'b0, '0);
        settle();
        write_cfg(CFG_QUEUE_DEPTH, phase_qd[p]);
      end
      write_cfg(CFG_NUM_LEVELS, phase_nl[p]);
      begin
        int deq_pct;
        deq_pct = $urandom_range(25, 65);
        repeat (PHASE_LEN) random_word(deq_pct);
      end
    end

    settle();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mlpq_pkg.sv
rtl/core/mlpq_ram.sv
rtl/core/mlpq_ctrl.sv
rtl/core/mlpq_dp.sv
rtl/core/multilevel_priority_fifo.sv
sim/testbench.sv
